>>> rtl/awd_pkg.sv
package awd_pkg;

   localparam int GuidBytes = 16;
   localparam int SizeEnd   = 24;
   localparam int MarkLen   = 18;
   localparam int WinLen    = MarkLen - 1;

   // header size limits, exclusive low and inclusive high
   localparam logic [4:0]  SIZE_MIN_EXCL = 5'd30;
   localparam logic [29:0] SIZE_MAX_INCL = 30'h3FFF_FFFE;

   typedef enum logic [1:0] {
      PH_GUID,
      PH_SIZE,
      PH_SCAN,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      VERDICT_CLEAR     = 2'd0,
      VERDICT_PROTECTED = 2'd1,
      VERDICT_UNDERFLOW = 2'd2,
      VERDICT_OVERFLOW  = 2'd3
   } verdict_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctl_type;

   // header-object guid in raw file byte order
   localparam logic [7:0] ASF_GUID [GuidBytes] = '{
      8'h30, 8'h26, 8'hB2, 8'h75, 8'h8E, 8'h66, 8'hCF, 8'h11,
      8'hA6, 8'hD9, 8'h00, 8'hAA, 8'h00, 8'h62, 8'hCE, 8'h6C
   };

   // "WRMHEADER" in utf-16le
   localparam logic [7:0] WRM_MARKER [MarkLen] = '{
      8'h57, 8'h00, 8'h52, 8'h00, 8'h4D, 8'h00, 8'h48, 8'h00, 8'h45,
      8'h00, 8'h41, 8'h00, 8'h44, 8'h00, 8'h45, 8'h00, 8'h52, 8'h00
   };

endpackage

>>> rtl/awd_req_if.sv
interface awd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

>>> rtl/awd_rsp_if.sv
interface awd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

>>> rtl/awd_marker_window.sv
module awd_marker_window
   import awd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  win_ctl_type ctl,
   input  logic [7:0]  data_byte,
   output logic        hit
);

   localparam int FillW = $clog2(WinLen + 1);

   logic [7:0]       recent_ff [WinLen];
   logic [FillW-1:0] fill_ff;
   logic [FillW-1:0] fill_in;
   logic             window_match;

   always_comb begin
      window_match = 1'b1;
      for (int i = 0; i < WinLen; i++) begin
         if (recent_ff[i] != WRM_MARKER[i]) window_match = 1'b0;
      end
      hit = (fill_ff == FillW'(WinLen)) && window_match
            && (data_byte == WRM_MARKER[MarkLen-1]);
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctl.clear) begin
         fill_in = '0;
      end else if (ctl.shift && fill_ff != FillW'(WinLen)) begin
         fill_in = fill_ff + FillW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // a hit counts only once the window is full, so stale entries need no clear
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         for (int i = 0; i < WinLen - 1; i++) recent_ff[i] <= recent_ff[i+1];
         recent_ff[WinLen-1] <= data_byte;
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillW'(WinLen))
      else $error("window fill beyond window length");

   a_fill_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> fill_ff == '0)
      else $error("window fill not cleared");

   a_hit_needs_fill: assert property (@(posedge clock) disable iff (reset)
      hit |-> $past(ctl.shift) || fill_ff == FillW'(WinLen))
      else $error("marker hit with partial window");
`endif

endmodule

>>> rtl/asf_wmdrm_header_detector.sv
// Scans one file a byte at a time for a DRM-protected ASF header: checks the
// header-object guid in bytes 0-15, takes bytes 16-23 as the little-endian
// header size, then looks for the utf-16 "WRMHEADER" marker inside the rest
// of the header. At most one verdict per file (0 clear, 1 protected,
// 2 underflow, 3 overflow); bytes after the verdict give nothing until the
// byte flagged end_of_file, which rearms the block. One byte is taken every
// cycle unless stalled; its verdict shows the next cycle. The only stall is
// the output register: req ready drops only while a verdict sits unread.
module asf_wmdrm_header_detector
   import awd_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   awd_req_if.sink   req,
   awd_rsp_if.source rsp
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  hoff_ff, hoff_in;
   logic        gm_ff, gm_in;
   logic [55:0] len_ff, len_in;
   logic [29:0] rem_ff, rem_in;
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type verdict_ff, verdict_in;

   logic        fire;
   logic        emit;
   verdict_type verdict_new;
   logic        mism;
   logic [63:0] full_len;
   logic        hit;
   win_ctl_type win_ctl;
   logic [3:0]  goff;
   logic [2:0]  sidx;

   assign req.ready   = !rsp_valid_ff || rsp.ready;
   assign fire        = req.valid && req.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.verdict = verdict_ff;
   assign goff        = hoff_ff[3:0];
   assign sidx        = hoff_ff[2:0];
   assign full_len    = {req.data_byte, len_ff};
   assign mism        = gm_ff || (req.data_byte != ASF_GUID[goff]);

   awd_marker_window u_window (
      .clock     (clock),
      .reset     (reset),
      .ctl       (win_ctl),
      .data_byte (req.data_byte),
      .hit       (hit)
   );

   always_comb begin
      phase_in    = phase_ff;
      hoff_in     = hoff_ff;
      gm_in       = gm_ff;
      len_in      = len_ff;
      rem_in      = rem_ff;
      emit        = 1'b0;
      verdict_new = VERDICT_CLEAR;
      win_ctl     = '0;
      if (fire) begin
         unique case (phase_ff)
            PH_GUID: begin
               gm_in   = mism;
               hoff_in = hoff_ff + 5'd1;
               if (goff == 4'(GuidBytes - 1)) begin
                  priority if (mism) begin
                     emit     = 1'b1;
                     phase_in = PH_DONE;
                  end else if (req.end_of_file) begin
                     emit        = 1'b1;
                     verdict_new = VERDICT_UNDERFLOW;
                  end else begin
                     phase_in = PH_SIZE;
                  end
               end else if (req.end_of_file) begin
                  emit        = 1'b1;
                  verdict_new = VERDICT_UNDERFLOW;
               end
            end
            PH_SIZE: begin
               hoff_in = hoff_ff + 5'd1;
               for (int i = 0; i < 7; i++) begin
                  if (sidx == 3'(i)) len_in[8*i +: 8] = req.data_byte;
               end
               if (sidx == 3'd7) begin
                  // negative sizes land in underflow
                  priority if (full_len[63]
                               || (full_len[62:5] == '0
                                   && full_len[4:0] <= SIZE_MIN_EXCL)) begin
                     emit        = 1'b1;
                     verdict_new = VERDICT_UNDERFLOW;
                     phase_in    = PH_DONE;
                  end else if (full_len[62:30] != '0
                               || full_len[29:0] > SIZE_MAX_INCL) begin
                     emit        = 1'b1;
                     verdict_new = VERDICT_OVERFLOW;
                     phase_in    = PH_DONE;
                  end else begin
                     rem_in        = full_len[29:0] - 30'(SizeEnd);
                     win_ctl.clear = 1'b1;
                     phase_in      = PH_SCAN;
                     emit          = req.end_of_file;
                  end
               end else if (req.end_of_file) begin
                  emit        = 1'b1;
                  verdict_new = VERDICT_UNDERFLOW;
               end
            end
            PH_SCAN: begin
               win_ctl.shift = 1'b1;
               if (rem_ff != '0) rem_in = rem_ff - 30'd1;
               priority if (hit) begin
                  emit        = 1'b1;
                  verdict_new = VERDICT_PROTECTED;
                  phase_in    = PH_DONE;
               end else if (rem_in == '0 || req.end_of_file) begin
                  emit     = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_SCAN;
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_GUID;
            end
         endcase
         if (req.end_of_file) begin
            phase_in      = PH_GUID;
            hoff_in       = '0;
            gm_in         = 1'b0;
            rem_in        = '0;
            win_ctl.clear = 1'b1;
         end
      end
   end

   always_comb begin
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = emit;
         if (emit) verdict_in = verdict_new;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_GUID;
         hoff_ff      <= '0;
         gm_ff        <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hoff_ff      <= hoff_in;
         gm_ff        <= gm_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      verdict_ff <= verdict_in;
   end

`ifndef SYNTHESIS
   a_eof_rearms: assert property (@(posedge clock) disable iff (reset)
      fire && req.end_of_file |=> phase_ff == PH_GUID && hoff_ff == '0 && !gm_ff)
      else $error("block not rearmed after last byte");

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_DONE |=> !rsp_valid_ff)
      else $error("verdict after file already decided");

   a_protect_from_scan: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff != PH_SCAN |=> !(rsp_valid_ff && verdict_ff == VERDICT_PROTECTED))
      else $error("protected verdict outside marker scan");

   a_guid_offset: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SIZE |-> hoff_ff >= 5'(GuidBytes) && hoff_ff < 5'(SizeEnd))
      else $error("size byte offset out of range");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import awd_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       drain;   // hold this byte back until every verdict is in
   } byte_item_type;

   logic clock = 1'b0;
   logic reset;

   awd_req_if req ();
   awd_rsp_if rsp ();

   asf_wmdrm_header_detector dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   byte_item_type pending_bytes[$];
   verdict_type   expected_verdicts[$];
   logic [7:0]    file_bytes[$];
   int            byte_total;
   int            file_count;
   int            fail_count = 0;
   int            idle_left;
   int            stall_left;
   bit            send_burst;
   bit            recv_burst;

   // header parser mirror
   phase_type   pr_phase;
   logic [4:0]  pr_offset;
   logic        pr_guid_bad;
   logic [63:0] pr_length;
   logic [29:0] pr_left;
   int          pr_fill;
   logic [7:0]  pr_window [WinLen];

   function automatic void rearm_parser();
      pr_phase    = PH_GUID;
      pr_offset   = '0;
      pr_guid_bad = 1'b0;
      pr_length   = '0;
      pr_left     = '0;
      pr_fill     = 0;
      foreach (pr_window[i]) pr_window[i] = 8'h00;
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic eof);
      logic        emit;
      logic        hit;
      logic [3:0]  off;
      logic [2:0]  idx;
      verdict_type v;
      emit = 1'b0;
      hit  = 1'b0;
      v    = VERDICT_CLEAR;
      case (pr_phase)
         PH_GUID: begin
            off = pr_offset[3:0];
            if (b != ASF_GUID[off]) pr_guid_bad = 1'b1;
            pr_offset = {1'b0, off} + 5'd1;
            if (off == 4'(GuidBytes - 1)) begin
               if (pr_guid_bad) begin
                  emit = 1'b1;
                  v = VERDICT_CLEAR;
                  pr_phase = PH_DONE;
               end else if (eof) begin
                  emit = 1'b1;
                  v = VERDICT_UNDERFLOW;
               end else begin
                  pr_phase = PH_SIZE;
               end
            end else if (eof) begin
               emit = 1'b1;
               v = VERDICT_UNDERFLOW;
            end
         end
         PH_SIZE: begin
            // size bytes sit at offsets 16..23, so the low three bits index them
            idx = pr_offset[2:0];
            pr_length = pr_length | (64'(b) << (8 * idx));
            pr_offset = pr_offset + 5'd1;
            if (idx == 3'd7) begin
               if (pr_length[63] || pr_length <= 64'(SIZE_MIN_EXCL)) begin
                  emit = 1'b1;
                  v = VERDICT_UNDERFLOW;
                  pr_phase = PH_DONE;
               end else if (pr_length > 64'(SIZE_MAX_INCL)) begin
                  emit = 1'b1;
                  v = VERDICT_OVERFLOW;
                  pr_phase = PH_DONE;
               end else begin
                  pr_left = 30'(pr_length - 64'(SizeEnd));
                  pr_fill = 0;
                  pr_phase = PH_SCAN;
                  if (eof) begin
                     emit = 1'b1;
                     v = VERDICT_CLEAR;
                  end
               end
            end else if (eof) begin
               emit = 1'b1;
               v = VERDICT_UNDERFLOW;
            end
         end
         PH_SCAN: begin
            hit = (pr_fill >= WinLen) && (b == WRM_MARKER[MarkLen - 1]);
            for (int i = 0; i < WinLen; i++) begin
               if (pr_window[i] != WRM_MARKER[i]) hit = 1'b0;
            end
            for (int i = 0; i < WinLen - 1; i++) pr_window[i] = pr_window[i + 1];
            pr_window[WinLen - 1] = b;
            if (pr_fill < WinLen) pr_fill++;
            if (pr_left != 0) pr_left--;
            if (hit) begin
               emit = 1'b1;
               v = VERDICT_PROTECTED;
               pr_phase = PH_DONE;
            end else if (pr_left == 0 || eof) begin
               emit = 1'b1;
               v = VERDICT_CLEAR;
               pr_phase = PH_DONE;
            end
         end
         default: ;
      endcase
      if (eof) rearm_parser();
      if (emit) expected_verdicts.push_back(v);
   endfunction

   // file builders
   function automatic void put_guid(input int bad_pos);
      logic [7:0] b;
      for (int i = 0; i < GuidBytes; i++) begin
         b = ASF_GUID[i];
         if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
         file_bytes.push_back(b);
      end
   endfunction

   function automatic void put_size(input logic [63:0] sz);
      for (int i = 0; i < 8; i++) file_bytes.push_back(sz[8 * i +: 8]);
   endfunction

   function automatic void put_marker(input int flip_pos);
      logic [7:0] b;
      for (int i = 0; i < MarkLen; i++) begin
         b = WRM_MARKER[i];
         if (i == flip_pos) b = b ^ 8'($urandom_range(1, 255));
         file_bytes.push_back(b);
      end
   endfunction

   // random bytes leaning toward zeros and marker letters to provoke near misses
   function automatic void put_noise(input int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0, 1:    file_bytes.push_back(8'($urandom));
            2:       file_bytes.push_back(8'h00);
            default: file_bytes.push_back(WRM_MARKER[$urandom_range(0, MarkLen - 1)]);
         endcase
      end
   endfunction

   function automatic void cut_file(input int len);
      while (file_bytes.size() > len) void'(file_bytes.pop_back());
   endfunction

   function automatic void ship_file(input bit drain);
      byte_item_type it;
      foreach (file_bytes[i]) begin
         it.data  = file_bytes[i];
         it.last  = (i == file_bytes.size() - 1);
         it.drain = drain && (i == 0);
         pending_bytes.push_back(it);
      end
      byte_total += file_bytes.size();
      file_count++;
      file_bytes.delete();
   endfunction

   function automatic int pick_idle(input bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] any_scan_size();
      return 64'($urandom_range(31, SIZE_MAX_INCL));
   endfunction

   // sender: one transfer per handshake, random gaps between bytes
   always @(posedge clock) begin : drive_bytes
      byte_item_type next_item;
      if (reset) begin
         req.valid <= 1'b0;
         idle_left = 0;
         rearm_parser();
      end else if (!req.valid || req.ready) begin
         if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
         if (idle_left > 0) begin
            idle_left--;
            req.valid <= 1'b0;
         end else if (pending_bytes.size() != 0 &&
                      !(pending_bytes[0].drain && expected_verdicts.size() != 0)) begin
            next_item = pending_bytes.pop_front();
            parse_byte(next_item.data, next_item.last);
            req.valid       <= 1'b1;
            req.data_byte   <= next_item.data;
            req.end_of_file <= next_item.last;
            idle_left = pick_idle(send_burst);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, checks each verdict transfer in order
   always @(posedge clock) begin : watch_verdicts
      verdict_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_verdicts.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected verdict %0d with none pending", rsp.verdict);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp.verdict !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("verdict mismatch: expected %0d (%s), got %0d",
                              want, want.name(), rsp.verdict);
               end
            end
         end
         if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
         if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_idle(recv_burst);
         end
      end
   end

   initial begin : run_files
      int scan_len;
      int kind;
      reset           = 1'b1;
      byte_total      = 0;
      file_count      = 0;

      // guid wrong on first byte, trailing bytes ignored
      put_guid(0); put_noise(6); ship_file(1'b0);
      // file ends inside the guid
      put_guid(-1); cut_file(5); ship_file(1'b0);
      // good guid that ends on its last byte
      put_guid(-1); ship_file(1'b0);
      // guid wrong on its last byte, which also ends the file
      put_guid(15); ship_file(1'b0);
      // guid wrong early, file ends before the guid is through
      put_guid(2); cut_file(9); ship_file(1'b0);
      // one-byte file
      file_bytes.push_back(8'hFF); ship_file(1'b0);
      // size at the underflow limit, negative sizes, overflow limit and beyond
      put_guid(-1); put_size(64'(SIZE_MIN_EXCL)); put_noise(3); ship_file(1'b1);
      put_guid(-1); put_size(64'hFFFF_FFFF_FFFF_FFFF); ship_file(1'b0);
      put_guid(-1); put_size(64'h8000_0000_0000_0040); put_noise(2); ship_file(1'b0);
      put_guid(-1); put_size(64'(SIZE_MAX_INCL) + 64'd1); ship_file(1'b0);
      put_guid(-1); put_size(64'h7FFF_FFFF_FFFF_FFFF); ship_file(1'b0);
      // largest valid size, file ends right after the size
      put_guid(-1); put_size(64'(SIZE_MAX_INCL)); ship_file(1'b0);
      // smallest valid size, scan runs out
      put_guid(-1); put_size(64'd31); put_noise(7); put_noise(4); ship_file(1'b1);
      // marker fills the scan exactly, and one short of it
      put_guid(-1); put_size(64'(SizeEnd + MarkLen)); put_marker(-1); ship_file(1'b0);
      put_guid(-1); put_size(64'(SizeEnd + MarkLen - 1)); put_marker(-1); ship_file(1'b0);
      // marker ending on the last byte of the file
      put_guid(-1); put_size(64'(SIZE_MAX_INCL)); put_marker(-1); ship_file(1'b0);
      // file ends mid-scan
      put_guid(-1); put_size(64'd200); put_noise(10); ship_file(1'b0);
      // near miss on the final marker byte, then the real marker
      put_guid(-1); put_size(64'd100); put_marker(MarkLen - 1); put_marker(-1);
      put_noise(2); ship_file(1'b1);

      while (byte_total < 1850 || file_count < 40) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 3000)
                                                   : $urandom_range(7, 48);
            put_guid(-1);
            put_size(64'(scan_len + SizeEnd));
            put_noise($urandom_range(0, (scan_len < 40) ? scan_len : 40));
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: put_marker(-1);
               6, 7:             put_marker($urandom_range(0, MarkLen - 1));
               default: ;
            endcase
            put_noise($urandom_range(0, 6));
            if ($urandom_range(0, 7) == 0) cut_file($urandom_range(1, file_bytes.size()));
         end else if (kind < 75) begin
            put_guid(-1);
            case ($urandom_range(0, 5))
               0:       put_size(64'($urandom_range(0, 30)));
               1:       put_size(64'd31);
               2:       put_size(64'(SIZE_MAX_INCL));
               3:       put_size(64'(SIZE_MAX_INCL) + 64'd1);
               4:       put_size({$urandom, $urandom});
               default: put_size(any_scan_size());
            endcase
            put_noise($urandom_range(0, 30));
            if ($urandom_range(0, 1) == 0) put_marker(-1);
         end else if (kind < 90) begin
            put_guid($urandom_range(0, GuidBytes - 1));
            put_size(any_scan_size());
            put_marker(-1);
            put_noise($urandom_range(0, 4));
         end else begin
            put_guid(-1);
            put_size(any_scan_size());
            cut_file($urandom_range(1, SizeEnd - 1));
         end
         ship_file($urandom_range(0, 7) == 0);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || req.valid) @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin : watchdog
      #8000000;
      $display("tb failed");
      $finish;
   end

endmodule
